[design/assert_macros.svh]
// assertion macros, included by cpc_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/cpc_pkg.sv]
// shared types and constants of the chromaticity pixel classifier
`timescale 1ns / 1ps
package cpc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ConeW   = 17;
  localparam int unsigned SatW    = 8;
  localparam int unsigned SumW    = 10;  // r+g+b
  localparam int unsigned SqW     = 16;  // one channel squared
  localparam int unsigned LenW    = 17;  // r^2 + g^2
  localparam int unsigned TsqW    = 20;  // (r+g+b)^2
  localparam int unsigned ProjW   = 24;  // one weighted channel / projection magnitude
  localparam int unsigned SatSqW  = 16;  // saturation bound squared
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [13:0] SAT_SCALE_SQ = 14'd10000;

  localparam logic [WeightW-1:0] RED_WEIGHT_RST   = 16'd26843;
  localparam logic [WeightW-1:0] GREEN_WEIGHT_RST = 16'd18795;
  localparam logic [ConeW-1:0]   CONE_COS_SQ_RST  = 17'd64820;
  localparam logic [SatW-1:0]    MIN_SAT_RST      = 8'd50;
  localparam logic [SatW-1:0]    MAX_SAT_RST      = 8'd100;

  typedef enum logic [2:0] {
    REG_RED_WEIGHT   = 3'd0,
    REG_GREEN_WEIGHT = 3'd1,
    REG_CONE_COS_SQ  = 3'd2,
    REG_MIN_SAT      = 3'd3,
    REG_MAX_SAT      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [WeightW-1:0] red_weight;   // signed Q1.15
    logic [WeightW-1:0] green_weight; // signed Q1.15
    logic [ConeW-1:0]   cone_cos_sq;  // unsigned Q1.16
    logic [SatW-1:0]    min_sat;
    logic [SatW-1:0]    max_sat;
  } cfg_t;

  // payload handed from the front half to the back half
  typedef struct packed {
    logic              nonblack;
    logic [TsqW-1:0]   t_sq;
    logic [LenW-1:0]   len_sq;
    logic [ProjW-1:0]  proj_abs;
    logic [SatSqW-1:0] min_sq;
    logic [SatSqW-1:0] max_sq;
  } mid_t;

endpackage

[design/cpc_cfg_regs.sv]
// apb register file holding the classifier settings
`timescale 1ns / 1ps
module cpc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cpc_pkg::AddrW-1:0] paddr,
  input  logic [cpc_pkg::DataW-1:0] pwdata,
  output logic [cpc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output cpc_pkg::cfg_t             cfg
);
  import cpc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_RED_WEIGHT:   cfg_nxt.red_weight   = pwdata[WeightW-1:0];
        REG_GREEN_WEIGHT: cfg_nxt.green_weight = pwdata[WeightW-1:0];
        REG_CONE_COS_SQ:  cfg_nxt.cone_cos_sq  = pwdata[ConeW-1:0];
        REG_MIN_SAT:      cfg_nxt.min_sat      = pwdata[SatW-1:0];
        REG_MAX_SAT:      cfg_nxt.max_sat      = pwdata[SatW-1:0];
        default:          cfg_nxt = cfg_r;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RED_WEIGHT:   prdata = DataW'(cfg_r.red_weight);
      REG_GREEN_WEIGHT: prdata = DataW'(cfg_r.green_weight);
      REG_CONE_COS_SQ:  prdata = DataW'(cfg_r.cone_cos_sq);
      REG_MIN_SAT:      prdata = DataW'(cfg_r.min_sat);
      REG_MAX_SAT:      prdata = DataW'(cfg_r.max_sat);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_weight   <= RED_WEIGHT_RST;
      cfg_r.green_weight <= GREEN_WEIGHT_RST;
      cfg_r.cone_cos_sq  <= CONE_COS_SQ_RST;
      cfg_r.min_sat      <= MIN_SAT_RST;
      cfg_r.max_sat      <= MAX_SAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/cpc_front.sv]
// first two pipeline stages: channel sums, squares and hue projection
`timescale 1ns / 1ps
module cpc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpc_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cpc_pkg::ChanW-1:0] blue,
  input  logic [cpc_pkg::ChanW-1:0] green,
  input  logic [cpc_pkg::ChanW-1:0] red,
  output logic                      mid_valid,
  input  logic                      mid_ready,
  output cpc_pkg::mid_t             mid
);
  import cpc_pkg::*;

  // stage 1
  logic                    v1_r;
  logic                    rdy1;
  logic [SumW-1:0]         sum1_r,   sum1_nxt;
  logic [SqW-1:0]          rsq1_r,   rsq1_nxt;
  logic [SqW-1:0]          gsq1_r,   gsq1_nxt;
  logic signed [ProjW-1:0] rproj1_r, rproj1_nxt;
  logic signed [ProjW-1:0] gproj1_r, gproj1_nxt;
  logic [SatSqW-1:0]       minsq1_r, minsq1_nxt;
  logic [SatSqW-1:0]       maxsq1_r, maxsq1_nxt;
  // stage 2
  logic                    v2_r;
  logic                    rdy2;
  mid_t                    mid2_r, mid2_nxt;
  logic signed [ProjW:0]   proj_sum;

  assign rdy2     = !v2_r || mid_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sum1_nxt   = SumW'(blue) + SumW'(green) + SumW'(red);
    rsq1_nxt   = SqW'(red) * SqW'(red);
    gsq1_nxt   = SqW'(green) * SqW'(green);
    rproj1_nxt = ProjW'($signed(cfg.red_weight)) * $signed(ProjW'(red));
    gproj1_nxt = ProjW'($signed(cfg.green_weight)) * $signed(ProjW'(green));
    minsq1_nxt = SatSqW'(cfg.min_sat) * SatSqW'(cfg.min_sat);
    maxsq1_nxt = SatSqW'(cfg.max_sat) * SatSqW'(cfg.max_sat);
  end

  always_comb begin
    proj_sum          = (ProjW+1)'(rproj1_r) + (ProjW+1)'(gproj1_r);
    mid2_nxt.nonblack = (sum1_r != '0);
    mid2_nxt.t_sq     = TsqW'(sum1_r) * TsqW'(sum1_r);
    mid2_nxt.len_sq   = LenW'(rsq1_r) + LenW'(gsq1_r);
    // magnitude stays below 2^24, so the negation fits
    mid2_nxt.proj_abs = proj_sum[ProjW] ? ProjW'(-proj_sum) : ProjW'(proj_sum);
    mid2_nxt.min_sq   = minsq1_r;
    mid2_nxt.max_sq   = maxsq1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sum1_r   <= sum1_nxt;
      rsq1_r   <= rsq1_nxt;
      gsq1_r   <= gsq1_nxt;
      rproj1_r <= rproj1_nxt;
      gproj1_r <= gproj1_nxt;
      minsq1_r <= minsq1_nxt;
      maxsq1_r <= maxsq1_nxt;
    end
    if (rdy2 && v1_r) begin
      mid2_r <= mid2_nxt;
    end
  end

  assign mid_valid = v2_r;
  assign mid       = mid2_r;

endmodule

[design/cpc_back.sv]
// last two pipeline stages: cross products, then the three compares
`timescale 1ns / 1ps
module cpc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cpc_pkg::cfg_t cfg,
  input  logic          mid_valid,
  output logic          mid_ready,
  input  cpc_pkg::mid_t mid,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_pass
);
  import cpc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned ProjSqW = 2 * ProjW;
  localparam int unsigned ConeProdW = ConeW + LenW;
  localparam int unsigned ScaledW = 31;
  localparam int unsigned BoundW = SatSqW + TsqW;

  // stage 3
  logic                 v3_r;
  logic                 rdy3;
  logic                 nonblack3_r, nonblack3_nxt;
  logic [ProjSqW-1:0]   projsq3_r,   projsq3_nxt;
  logic [ConeProdW-1:0] cone3_r,     cone3_nxt;
  logic [ScaledW-1:0]   scaled3_r,   scaled3_nxt;
  logic [BoundW-1:0]    low3_r,      low3_nxt;
  logic [BoundW-1:0]    high3_r,     high3_nxt;
  // stage 4, the output register
  logic                 v4_r;
  logic                 rdy4;
  logic                 pass4_r,     pass4_nxt;
  logic                 cone_ok, low_ok, high_ok;

  assign rdy4      = !v4_r || out_ready;
  assign rdy3      = !v3_r || rdy4;
  assign mid_ready = rdy3;

  always_comb begin
    nonblack3_nxt = mid.nonblack;
    projsq3_nxt   = ProjSqW'(mid.proj_abs) * ProjSqW'(mid.proj_abs);
    cone3_nxt     = ConeProdW'(cfg.cone_cos_sq) * ConeProdW'(mid.len_sq);
    scaled3_nxt   = ScaledW'(mid.len_sq) * ScaledW'(SAT_SCALE_SQ);
    low3_nxt      = BoundW'(mid.min_sq) * BoundW'(mid.t_sq);
    high3_nxt     = BoundW'(mid.max_sq) * BoundW'(mid.t_sq);
  end

  always_comb begin
    // cos^2 in q1.16 against q18.30 projection: align by 14 bits
    cone_ok   = projsq3_r > {cone3_r, 14'd0};
    low_ok    = low3_r < BoundW'(scaled3_r);
    high_ok   = high3_r > BoundW'(scaled3_r);
    pass4_nxt = nonblack3_r && cone_ok && low_ok && high_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= mid_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && mid_valid) begin
      nonblack3_r <= nonblack3_nxt;
      projsq3_r   <= projsq3_nxt;
      cone3_r     <= cone3_nxt;
      scaled3_r   <= scaled3_nxt;
      low3_r      <= low3_nxt;
      high3_r     <= high3_nxt;
    end
    if (rdy4 && v3_r) begin
      pass4_r <= pass4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_pass  = pass4_r;

  // a held word in stage 3 is not dropped while the output stalls
  `ASSERT_AT(a_s3_hold, clk, rst_n, v3_r && !rdy4 |=> v3_r)
  // a new output word only appears when stage 3 held one
  `ASSERT_AT(a_s4_source, clk, rst_n, $rose(v4_r) |-> $past(v3_r))
  // a black pixel carries zero chromaticity length through the products
  `ASSERT_AT(a_black_zero, clk, rst_n, v3_r && !nonblack3_r |-> scaled3_r == '0)

endmodule

[design/chromaticity_pixel_classifier.sv]
// top level of the chromaticity pixel classifier
`timescale 1ns / 1ps
// Classifies a stream of BGR pixels by their red/green chromaticity.
// in_*   : one pixel per word, tdata = {red, green, blue}, blue in the low byte.
// out_*  : one word per pixel, tdata bit 0 = in_range, the other bits zero.
// cfg_*  : apb register port, registers at byte offsets 0x00..0x10 in order
//          red_weight, green_weight, cone_cos_sq, min_saturation, max_saturation.
//          Write registers only while the pipeline is empty.
// A pixel passes when its projection on the hue direction lies inside the cone
// and its chromaticity length lies strictly inside the saturation band; a
// black pixel never passes. All tests are exact integer compares.
// Four register stages lie between the accepting edge and out_tvalid (sums/squares,
// projection magnitude, products, compares).
// Throughput: one word per clock while out_tready stays high, set by the fully pipelined multipliers.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults. When the receiver stalls, each stage holds its word and in_tready
// falls only once every stage between input and output is occupied.
module chromaticity_pixel_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,    // blue [7:0], green [15:8], red [23:16]
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,   // in_range [0], zero fill [7:1]
  // configuration
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [cpc_pkg::AddrW-1:0] cfg_paddr,
  input  logic [cpc_pkg::DataW-1:0] cfg_pwdata,
  output logic [cpc_pkg::DataW-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import cpc_pkg::*;

  cfg_t cfg;
  logic mid_valid;
  logic mid_ready;
  mid_t mid;
  logic pass;

  cpc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // stages 1 and 2
  cpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .blue      (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .red       (in_tdata[23:16]),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // stages 3 and 4, stage 4 drives the result port
  cpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pass  (pass)
  );

  assign out_tdata = {7'd0, pass};

endmodule
